// ----- sv/rsn_pkg.sv -----
// ----------------------------------------------------------------------------
// rsn_pkg
// Shared types, constants and helpers of the record sorter.
// ----------------------------------------------------------------------------
package rsn_pkg;

  localparam int unsigned MaxRecordsDef = 64;
  localparam int unsigned NameBytesDef  = 16;
  localparam int unsigned NameBytesMax  = 16;

  localparam int unsigned NameWordW = 64;
  localparam int unsigned NameW     = 2 * NameWordW;
  localparam int unsigned IdW       = 27;
  localparam int unsigned AgeW      = 10;
  localparam int unsigned ZlenW     = $clog2(NameBytesMax + 1);

  typedef logic [ZlenW-1:0] zlen_t;

  typedef struct packed {
    logic [NameWordW-1:0] name_high;
    logic [NameWordW-1:0] name_low;
    logic [IdW-1:0]       id_number;
    logic [AgeW-1:0]      age;
    logic                 active;
    zlen_t                zlen;
  } rec_t;

  // Number of leading name bytes that take part in a comparison.
  function automatic zlen_t name_len(logic [NameW-1:0] name, int unsigned nbytes);
    zlen_t z;
    logic  found;
    z     = zlen_t'(NameBytesMax);
    found = 1'b0;
    for (int unsigned k = 0; k < NameBytesMax; k++) begin
      if (!found && ((k >= nbytes) || (name[NameW-1-8*k -: 8] == 8'h00))) begin
        z     = zlen_t'(k);
        found = 1'b1;
      end
    end
    return z;
  endfunction

endpackage

// ----- sv/rsn_if.sv -----
// ----------------------------------------------------------------------------
// rsn_in_if / rsn_out_if
// Valid/ready channels for incoming records and sorted results.
// ----------------------------------------------------------------------------
interface rsn_in_if;
  import rsn_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [NameWordW-1:0] name_high;
  logic [NameWordW-1:0] name_low;
  logic [IdW-1:0]       id_number;
  logic [AgeW-1:0]      age;
  logic                 active;
  logic                 last;

  modport source (
    output valid, name_high, name_low, id_number, age, active, last,
    input  ready
  );
  modport sink (
    input  valid, name_high, name_low, id_number, age, active, last,
    output ready
  );
endinterface

interface rsn_out_if;
  import rsn_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [NameWordW-1:0] out_name_high;
  logic [NameWordW-1:0] out_name_low;
  logic [IdW-1:0]       out_id_number;
  logic [AgeW-1:0]      out_age;
  logic                 out_active;
  logic                 out_last;

  modport source (
    output valid, out_name_high, out_name_low, out_id_number, out_age, out_active,
           out_last,
    input  ready
  );
  modport sink (
    input  valid, out_name_high, out_name_low, out_id_number, out_age, out_active,
           out_last,
    output ready
  );
endinterface

// ----- sv/rsn_key_cmp.sv -----
// ----------------------------------------------------------------------------
// rsn_key_cmp
// Composite key compare: name bytewise up to its end, then id number.
// ----------------------------------------------------------------------------
module rsn_key_cmp (
  input  rsn_pkg::rec_t a_i,
  input  rsn_pkg::rec_t b_i,
  output logic          a_gt_b_o
);
  import rsn_pkg::*;

  logic [NameW-1:0] name_a;
  logic [NameW-1:0] name_b;
  logic [NameW-1:0] mname_a;
  logic [NameW-1:0] mname_b;

  assign name_a = {a_i.name_high, a_i.name_low};
  assign name_b = {b_i.name_high, b_i.name_low};

  // Clear bytes past the end of each name.
  always_comb begin
    for (int unsigned k = 0; k < NameBytesMax; k++) begin
      mname_a[NameW-1-8*k -: 8] = (zlen_t'(k) < a_i.zlen) ? name_a[NameW-1-8*k -: 8] : 8'h00;
      mname_b[NameW-1-8*k -: 8] = (zlen_t'(k) < b_i.zlen) ? name_b[NameW-1-8*k -: 8] : 8'h00;
    end
  end

  assign a_gt_b_o = {mname_a, a_i.id_number} > {mname_b, b_i.id_number};

endmodule

// ----- sv/record_sort_by_name_then_id.sv -----
// ----------------------------------------------------------------------------
// record_sort_by_name_then_id
// Collects person records into a record memory, sorts them by name and then
// id number with an exchange sort, and streams them out in order.
// ----------------------------------------------------------------------------
// Records load at one per cycle while the block is collecting. The record
// that carries last starts the sort over the n records held (n up to
// MAX_RECORDS; records past capacity are dropped). The sort runs through the
// single read port of the record memory, one comparison per cycle, and no
// input is taken meanwhile. The sorted records then leave one at a time,
// each read from the record memory and then loaded into the output register,
// the final one flagged with out_last, and the block is ready for the next
// set as the final result enters the output register.
// ----------------------------------------------------------------------------
module record_sort_by_name_then_id #(
  parameter int unsigned MAX_RECORDS = rsn_pkg::MaxRecordsDef,
  parameter int unsigned NAME_BYTES  = rsn_pkg::NameBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rsn_in_if.sink           in_i,
  rsn_out_if.source        out_o
);
  import rsn_pkg::*;

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RDI  = 3'd1;
  localparam logic [2:0] S_LDI  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_WRI  = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_EOUT = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cnt_inc;
  logic [AW-1:0] i_q, i_d;
  logic [AW-1:0] cj_q, cj_d;
  rec_t          a_q, a_d;
  rec_t          rd_q;
  rec_t          in_rec;
  rec_t          wd;
  rec_t          mem [MAX_RECORDS];
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic          gt;
  logic          in_fire;
  logic          out_load;
  logic          out_last_d;
  logic          out_valid_q;
  logic          out_last_q;
  rec_t          out_rec_q;

  assign in_rec.name_high = in_i.name_high;
  assign in_rec.name_low  = in_i.name_low;
  assign in_rec.id_number = in_i.id_number;
  assign in_rec.age       = in_i.age;
  assign in_rec.active    = in_i.active;
  assign in_rec.zlen      = name_len({in_i.name_high, in_i.name_low}, NAME_BYTES);

  assign in_i.ready = (state_q == S_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;

  rsn_key_cmp u_key_cmp (
    .a_i      (a_q),
    .b_i      (rd_q),
    .a_gt_b_o (gt)
  );

  // Record memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    i_d        = i_q;
    cj_d       = cj_q;
    a_d        = a_q;
    we         = 1'b0;
    wa         = '0;
    wd         = a_q;
    re         = 1'b0;
    ra         = '0;
    out_load   = 1'b0;
    out_last_d = 1'b0;
    cnt_inc    = cnt_q;

    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (cnt_q < CW'(MAX_RECORDS)) begin
            we      = 1'b1;
            wa      = cnt_q[AW-1:0];
            wd      = in_rec;
            cnt_inc = cnt_q + CW'(1);
          end
          cnt_d = cnt_inc;
          if (in_i.last) begin
            i_d     = '0;
            state_d = (cnt_inc >= CW'(2)) ? S_RDI : S_ERD;
          end
        end
      end
      S_RDI: begin
        re      = 1'b1;
        ra      = i_q;
        state_d = S_LDI;
      end
      S_LDI: begin
        a_d     = rd_q;
        re      = 1'b1;
        ra      = i_q + AW'(1);
        cj_d    = i_q + AW'(1);
        state_d = S_CMP;
      end
      S_CMP: begin
        // swap: hold the smaller key, write the larger back
        if (gt) begin
          we  = 1'b1;
          wa  = cj_q;
          wd  = a_q;
          a_d = rd_q;
        end
        if ((CW'(cj_q) + CW'(1)) < cnt_q) begin
          re   = 1'b1;
          ra   = cj_q + AW'(1);
          cj_d = cj_q + AW'(1);
        end else begin
          state_d = S_WRI;
        end
      end
      S_WRI: begin
        we = 1'b1;
        wa = i_q;
        wd = a_q;
        if ((CW'(i_q) + CW'(2)) < cnt_q) begin
          i_d     = i_q + AW'(1);
          state_d = S_RDI;
        end else begin
          i_d     = '0;
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        re      = 1'b1;
        ra      = i_q;
        state_d = S_EOUT;
      end
      S_EOUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load   = 1'b1;
          out_last_d = (CW'(i_q) + CW'(1)) == cnt_q;
          if (out_last_d) begin
            cnt_d   = '0;
            i_d     = '0;
            state_d = S_LOAD;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      i_q         <= '0;
      cj_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      cj_q    <= cj_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    if (out_load) begin
      out_rec_q  <= rd_q;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_name_high = out_rec_q.name_high;
  assign out_o.out_name_low  = out_rec_q.name_low;
  assign out_o.out_id_number = out_rec_q.id_number;
  assign out_o.out_age       = out_rec_q.age;
  assign out_o.out_active    = out_rec_q.active;
  assign out_o.out_last      = out_last_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RECORDS))
    else $error("record count beyond capacity");

  a_cmp_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (cj_q > i_q))
    else $error("compare position not above held position");

  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && we && re) |-> (wa != ra))
    else $error("read and write of the same entry in one cycle");

  a_emit_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EOUT || state_q == S_ERD) |-> (cnt_q != '0))
    else $error("emission with an empty set");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=>
      (out_valid_q && $stable(out_rec_q) && $stable(out_last_q)))
    else $error("result changed while waiting");

endmodule

// ----- tb/record_sort_by_name_then_id_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_sort_by_name_then_id_test
// Streams person records into the sorter in sets closed by last, predicts the
// sorted order with its own exchange sort on name and id, checks every emitted
// record field by field. Both channels idle in random bursts before QuietFrom.
// ----------------------------------------------------------------------------
module record_sort_by_name_then_id_test;
  import rsn_pkg::*;

  localparam int unsigned Capacity   = MaxRecordsDef;
  localparam int unsigned NameBytes  = NameBytesDef;
  localparam int          TotalItems = 470;
  localparam int          QuietFrom  = 400;
  localparam int          StallLimit = 20000;
  localparam int unsigned IdTop      = 99999999;

  typedef struct packed {
    logic [NameWordW-1:0] name_high;
    logic [NameWordW-1:0] name_low;
    logic [IdW-1:0]       id_number;
    logic [AgeW-1:0]      age;
    logic                 active;
  } person_t;

  typedef struct packed {
    person_t person;
    logic    last;
  } sorted_person_t;

  class record_sort_scoreboard;
    person_t        held_set[$];
    sorted_person_t sorted_due[$];
    int             mismatches;
    int             records_in;
    int             records_dropped;
    int             sets_sorted;
    int             results_checked;

    function int compare_names(person_t a, person_t b);
      logic [NameW-1:0] na;
      logic [NameW-1:0] nb;
      logic [7:0]       x;
      logic [7:0]       y;
      na = {a.name_high, a.name_low};
      nb = {b.name_high, b.name_low};
      for (int k = 0; k < NameBytes; k++) begin
        x = na[NameW-1-8*k -: 8];
        y = nb[NameW-1-8*k -: 8];
        if (x != y) return (x > y) ? 1 : -1;
        if (x == 8'h00) return 0;
      end
      return 0;
    endfunction

    function void swap_held(int i, int j);
      person_t t;
      t           = held_set[i];
      held_set[i] = held_set[j];
      held_set[j] = t;
    endfunction

    function void sort_by_name_then_id();
      int n;
      n = held_set.size();
      for (int i = 0; i + 1 < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (compare_names(held_set[i], held_set[j]) > 0) swap_held(i, j);
          if (compare_names(held_set[i], held_set[j]) == 0 &&
              held_set[i].id_number > held_set[j].id_number) swap_held(i, j);
        end
      end
    endfunction

    function void note_record(person_t p, logic last);
      sorted_person_t s;
      records_in++;
      if (held_set.size() < Capacity) held_set.push_back(p);
      else records_dropped++;
      if (!last) return;
      sort_by_name_then_id();
      foreach (held_set[k]) begin
        s.person = held_set[k];
        s.last   = (k == held_set.size() - 1);
        sorted_due.push_back(s);
      end
      held_set.delete();
      sets_sorted++;
    endfunction

    function void check_result(sorted_person_t got);
      sorted_person_t want;
      if (sorted_due.size() == 0) begin
        $error("unexpected result: name %h_%h id %0d", got.person.name_high,
               got.person.name_low, got.person.id_number);
        mismatches++;
        return;
      end
      want = sorted_due.pop_front();
      results_checked++;
      if (got.person.name_high !== want.person.name_high) begin
        $error("out_name_high: expected %h, actual %h", want.person.name_high,
               got.person.name_high);
        mismatches++;
      end
      if (got.person.name_low !== want.person.name_low) begin
        $error("out_name_low: expected %h, actual %h", want.person.name_low,
               got.person.name_low);
        mismatches++;
      end
      if (got.person.id_number !== want.person.id_number) begin
        $error("out_id_number: expected %0d, actual %0d", want.person.id_number,
               got.person.id_number);
        mismatches++;
      end
      if (got.person.age !== want.person.age) begin
        $error("out_age: expected %0d, actual %0d", want.person.age, got.person.age);
        mismatches++;
      end
      if (got.person.active !== want.person.active) begin
        $error("out_active: expected %0b, actual %0b", want.person.active,
               got.person.active);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0b, actual %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic quiet;
  int   items_sent;
  int   stall_cycles = 0;

  rsn_in_if  in_ch ();
  rsn_out_if out_ch ();

  record_sort_scoreboard sb = new;
  logic [NameW-1:0]      name_pool[$];

  record_sort_by_name_then_id dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      sb.note_record('{in_ch.name_high, in_ch.name_low, in_ch.id_number, in_ch.age,
                       in_ch.active}, in_ch.last);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_result('{'{out_ch.out_name_high, out_ch.out_name_low,
                          out_ch.out_id_number, out_ch.out_age, out_ch.out_active},
                        out_ch.out_last});
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles", StallLimit);
      $display("FAILURE");
      $finish;
    end
  end

  // hold ready in random stretches, with stall bursts until the quiet part
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  function automatic logic [NameW-1:0] random_name();
    logic [NameW-1:0] v;
    int               mode;
    int               len;
    v    = '0;
    mode = $urandom_range(0, 9);
    if (mode == 0) return {$urandom, $urandom, $urandom, $urandom};
    if (mode <= 3 && name_pool.size() > 0)
      return name_pool[$urandom_range(0, name_pool.size() - 1)];
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 4);
    for (int k = 0; k < len; k++) begin
      v[NameW-1-8*k -: 8] = (mode <= 6) ? 8'(8'h41 + $urandom_range(0, 2))
                                        : 8'($urandom_range(1, 255));
    end
    // junk behind the terminator must not affect the order
    if (mode == 9) begin
      for (int k = len + 1; k < 16; k++) v[NameW-1-8*k -: 8] = 8'($urandom);
    end
    name_pool.push_back(v);
    if (name_pool.size() > 8) void'(name_pool.pop_front());
    return v;
  endfunction

  function automatic person_t random_person();
    person_t          p;
    logic [NameW-1:0] nm;
    nm          = random_name();
    p.name_high = nm[NameW-1 -: NameWordW];
    p.name_low  = nm[NameWordW-1:0];
    case ($urandom_range(0, 3))
      0:       p.id_number = IdW'($urandom_range(0, 2));
      1:       p.id_number = IdW'(IdTop - $urandom_range(0, 1));
      default: p.id_number = IdW'($urandom_range(0, IdTop));
    endcase
    p.age    = AgeW'($urandom_range(0, 999));
    p.active = 1'($urandom);
    return p;
  endfunction

  task automatic send_record(person_t p, logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.name_high <= p.name_high;
    in_ch.name_low  <= p.name_low;
    in_ch.id_number <= p.id_number;
    in_ch.age       <= p.age;
    in_ch.active    <= p.active;
    in_ch.last      <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    quiet = (items_sent >= QuietFrom);
  endtask

  task automatic send_name(logic [63:0] hi, logic [63:0] lo, int unsigned id,
                           int unsigned age, logic active, logic last);
    send_record('{hi, lo, IdW'(id), AgeW'(age), active}, last);
  endtask

  initial begin
    int set_no;
    int set_size;
    rst_ni          = 1'b0;
    quiet           = 1'b0;
    items_sent      = 0;
    in_ch.valid     = 1'b0;
    in_ch.name_high = '0;
    in_ch.name_low  = '0;
    in_ch.id_number = '0;
    in_ch.age       = '0;
    in_ch.active    = 1'b0;
    in_ch.last      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single record set
    send_name(64'h0, 64'h0, 0, 0, 1'b0, 1'b1);

    // extremes, unsigned bytes, junk after terminator, ties on name and id
    send_name('1, '1, IdTop, 999, 1'b1, 1'b0);
    send_name(64'h0, 64'h0, 0, 0, 1'b0, 1'b0);
    send_name(64'h4142_0058_0000_0000, 64'h0, 5, 11, 1'b1, 1'b0);
    send_name(64'h4142_0059_0000_0000, 64'h1234_5678_9abc_def0, 5, 22, 1'b0, 1'b0);
    send_name(64'h8000_0000_0000_0000, 64'h0, 7, 1, 1'b1, 1'b0);
    send_name(64'h7f00_0000_0000_0000, 64'h0, 7, 2, 1'b0, 1'b0);
    send_name(64'h4142_4344_4546_4748, 64'h4950_0000_0000_0000, IdTop, 3, 1'b1, 1'b0);
    send_name(64'h4142_4344_4546_4748, 64'h4950_0000_0000_0000, 0, 4, 1'b0, 1'b0);
    send_name(64'h4142_4344_4546_4748, 64'h4a4b_4c4d_4e4f_5052, 9, 5, 1'b1, 1'b0);
    send_name(64'h4142_4344_4546_4748, 64'h4a4b_4c4d_4e4f_5051, 9, 6, 1'b0, 1'b1);

    // reversed pair forces a swap
    send_name(64'h4200_0000_0000_0000, 64'h0, 1, 7, 1'b1, 1'b0);
    send_name(64'h4100_0000_0000_0000, 64'h0, 2, 8, 1'b0, 1'b1);

    set_no = 0;
    while (items_sent < TotalItems) begin
      if (set_no == 4) set_size = Capacity;
      else if (set_no == 9) set_size = $urandom_range(Capacity + 1, Capacity + 6);
      else if ($urandom_range(0, 9) == 0) set_size = $urandom_range(13, 40);
      else set_size = $urandom_range(1, 12);
      for (int k = 0; k < set_size; k++) send_record(random_person(), k == set_size - 1);
      set_no++;
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);

    while (sb.sorted_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d records in %0d sets, %0d dropped at a full store;",
             sb.records_in, sb.sets_sorted, sb.records_dropped);
    $display("checked %0d sorted results, %0d mismatches.", sb.results_checked,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rsn_pkg.sv
sv/rsn_if.sv
sv/rsn_key_cmp.sv
sv/record_sort_by_name_then_id.sv
tb/record_sort_by_name_then_id_test.sv
